// ----- src/line_buffer_blur_filter_core_defines.svh -----
// Assertion macros for the blur filter checker.
// Needs a clk and a rst signal in the scope of each use.
`ifndef LINE_BUFFER_BLUR_FILTER_CORE_DEFINES_SVH
`define LINE_BUFFER_BLUR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define LBBF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbbf_checker: property violated");

// Next-cycle implication, off while reset is high.
`define LBBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbbf_checker: property violated");

// Next-cycle implication that also checks across reset.
`define LBBF_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lbbf_checker: reset property violated");

`endif

// ----- src/lbbf_pkg.sv -----
// Shared types and constants of the line buffer blur filter.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package lbbf_pkg;

  typedef enum logic [1:0] {
    MODE_BOX3   = 2'd0,
    MODE_BOX5   = 2'd1,
    MODE_GAUSS3 = 2'd2,
    MODE_GAUSS5 = 2'd3
  } mode_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int PIX_W  = 8;
  localparam int ADDR_W = 11;
  localparam int LINES  = 4;
  localparam int WORD_W = LINES * PIX_W;

  // Middle queue and result queue depths (powers of two).
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QLVL_W  = $clog2(QDEPTH + 1);
  localparam int ODEPTH  = 4;
  localparam int OPTR_W  = $clog2(ODEPTH);
  localparam int OLVL_W  = $clog2(ODEPTH + 1);

  // Reciprocals for truncating division: exact over the sum ranges used.
  localparam logic [13:0] RECIP9        = 14'd7282;
  localparam int          RECIP9_SHIFT  = 16;
  localparam logic [13:0] RECIP25       = 14'd10486;
  localparam int          RECIP25_SHIFT = 18;

  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] frow;
    logic [ADDR_W-1:0] fcol;
    logic [PIX_W-1:0]  px;
    logic              filt;
    logic              frame_end;
  } pix_meta_t;

  typedef struct packed {
    logic [WORD_W-1:0] lines;
    pix_meta_t         meta;
  } col_item_t;

  typedef struct packed {
    logic                 empty;
    logic [QLVL_W-1:0]    level;
  } qstat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic [PIX_W-1:0]  value;
    logic              run_last;
    logic              frame_last;
  } result_t;

endpackage

`default_nettype wire

// ----- src/lbbf_ram.sv -----
// Generic single-clock RAM: one write port, one registered read port.
// Read during write to the same address returns the old word.
`default_nettype none

module lbbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/lbbf_front.sv -----
// Front end: configuration registers, raster counters, pixel classification
// and the four line stores. Uses lbbf_pkg and lbbf_ram.
`default_nettype none

module lbbf_front #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [lbbf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lbbf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 push,
  input  logic [lbbf_pkg::PIX_W-1:0]           pixel_value,
  output logic                                 full,
  input  lbbf_pkg::qstat_t                     q_stat,
  output logic                                 q_push,
  output lbbf_pkg::col_item_t                  q_item,
  output lbbf_pkg::mode_t                      filter_mode
);

  localparam int CB  = $clog2(MAX_COLS);
  localparam int RB  = $clog2(MAX_ROWS);
  localparam int CWB = $clog2(MAX_COLS + 1);
  localparam int RWB = $clog2(MAX_ROWS + 1);
  localparam int LW  = lbbf_pkg::QLVL_W + 1;
  localparam int W_RST = (2048 > MAX_COLS) ? MAX_COLS : 2048;
  localparam int H_RST = (2048 > MAX_ROWS) ? MAX_ROWS : 2048;
  localparam int AW  = lbbf_pkg::ADDR_W;

  logic [CWB-1:0] width_eff;
  logic [RWB-1:0] height_eff;
  logic [CB-1:0]  col;
  logic [RB-1:0]  row;

  logic           accept;
  logic [12:0]    cfg_ext;
  logic [12:0]    w_clamp;
  logic [12:0]    h_clamp;
  logic           k5;
  logic [2:0]     ksize;
  logic [2:0]     kreach;
  logic [2:0]     khalf;
  logic           filt;
  logic [CWB-1:0] col_inc;
  logic [RWB-1:0] row_inc;
  logic           row_end;
  logic           frame_end;
  logic [CB-1:0]  fcol;
  logic [RB-1:0]  frow;
  logic [CB+AW-1:0] col_x;
  logic [CB+AW-1:0] fcol_x;
  logic [RB+AW-1:0] row_x;
  logic [RB+AW-1:0] frow_x;
  logic [LW-1:0]  pending;

  // stage B: line store data returns
  logic                        b_valid;
  logic [CB-1:0]               b_col;
  lbbf_pkg::pix_meta_t         b_meta;
  logic [lbbf_pkg::WORD_W-1:0] rd_word;
  logic [lbbf_pkg::WORD_W-1:0] old_word;
  logic [lbbf_pkg::WORD_W-1:0] new_word;
  logic                        lw_valid;
  logic [CB-1:0]               lw_addr;
  logic [lbbf_pkg::WORD_W-1:0] lw_data;

  // Hold back while the queue might not take this item and the one in stage B.
  assign pending = LW'(q_stat.level) + LW'(b_valid);
  assign full    = pending >= LW'(lbbf_pkg::QDEPTH);
  assign accept  = push && !full;

  always_comb begin
    cfg_ext = {1'b0, cfg_data};
    if (cfg_data == '0) begin
      w_clamp = 13'd1;
      h_clamp = 13'd1;
    end else begin
      w_clamp = (cfg_ext > 13'(MAX_COLS)) ? 13'(MAX_COLS) : cfg_ext;
      h_clamp = (cfg_ext > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : cfg_ext;
    end
  end

  always_comb begin
    k5 = filter_mode inside {lbbf_pkg::MODE_BOX5, lbbf_pkg::MODE_GAUSS5};
    ksize  = k5 ? 3'd5 : 3'd3;
    kreach = k5 ? 3'd4 : 3'd2;
    khalf  = k5 ? 3'd2 : 3'd1;
    filt = (width_eff >= CWB'(ksize)) && (height_eff >= RWB'(ksize)) &&
           (row >= RB'(kreach)) && (col >= CB'(kreach));
    col_inc   = CWB'(col) + CWB'(1);
    row_inc   = RWB'(row) + RWB'(1);
    row_end   = col_inc >= width_eff;
    frame_end = row_end && (row_inc >= height_eff);
    frow   = row - RB'(khalf);
    fcol   = col - CB'(khalf);
    row_x  = {{AW{1'b0}}, row};
    col_x  = {{AW{1'b0}}, col};
    frow_x = {{AW{1'b0}}, frow};
    fcol_x = {{AW{1'b0}}, fcol};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= lbbf_pkg::MODE_BOX3;
      width_eff   <= CWB'(W_RST);
      height_eff  <= RWB'(H_RST);
      col         <= '0;
      row         <= '0;
      b_valid     <= 1'b0;
      lw_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          lbbf_pkg::REG_FILTER_MODE:  filter_mode <= lbbf_pkg::mode_t'(cfg_data[1:0]);
          lbbf_pkg::REG_IMAGE_WIDTH:  width_eff   <= CWB'(w_clamp);
          lbbf_pkg::REG_IMAGE_HEIGHT: height_eff  <= RWB'(h_clamp);
          default: ;
        endcase
      end
      if (accept) begin
        if (row_end) begin
          col <= '0;
          row <= frame_end ? '0 : row + RB'(1);
        end else begin
          col <= col + CB'(1);
        end
      end
      b_valid  <= accept;
      lw_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col            <= col;
      b_meta.row       <= row_x[AW-1:0];
      b_meta.col       <= col_x[AW-1:0];
      b_meta.frow      <= frow_x[AW-1:0];
      b_meta.fcol      <= fcol_x[AW-1:0];
      b_meta.px        <= pixel_value;
      b_meta.filt      <= filt;
      b_meta.frame_end <= frame_end;
    end
    lw_addr <= b_col;
    lw_data <= new_word;
  end

  // Forward the word written last cycle: the read raced that write.
  assign old_word = (lw_valid && (lw_addr == b_col)) ? lw_data : rd_word;
  assign new_word = {old_word[lbbf_pkg::WORD_W-lbbf_pkg::PIX_W-1:0], b_meta.px};

  lbbf_ram #(
    .WIDTH (lbbf_pkg::WORD_W),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (new_word),
    .raddr (col),
    .rdata (rd_word)
  );

  assign q_push       = b_valid;
  assign q_item.lines = old_word;
  assign q_item.meta  = b_meta;

endmodule

`default_nettype wire

// ----- src/lbbf_queue.sv -----
// Short queue of classified pixel columns between front and back end.
// Uses lbbf_pkg for the item type and depth.
`default_nettype none

module lbbf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lbbf_pkg::col_item_t din,
  input  logic                pop,
  output lbbf_pkg::col_item_t dout,
  output lbbf_pkg::qstat_t    stat
);

  lbbf_pkg::col_item_t              mem [lbbf_pkg::QDEPTH];
  logic [lbbf_pkg::QPTR_W-1:0]      wp;
  logic [lbbf_pkg::QPTR_W-1:0]      rp;
  logic [lbbf_pkg::QLVL_W-1:0]      level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= wp + lbbf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rp <= rp + lbbf_pkg::QPTR_W'(1);
      end
      level <= level + lbbf_pkg::QLVL_W'(push) - lbbf_pkg::QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  assign dout       = mem[rp];
  assign stat.level = level;
  assign stat.empty = (level == '0);

endmodule

`default_nettype wire

// ----- src/lbbf_back.sv -----
// Back end: 5x5 window, kernel sum pipeline, division and result queue.
// Uses lbbf_pkg; fed by lbbf_queue.
`default_nettype none

module lbbf_back (
  input  logic                             clk,
  input  logic                             rst,
  input  lbbf_pkg::mode_t                  filter_mode,
  input  lbbf_pkg::qstat_t                 q_stat,
  input  lbbf_pkg::col_item_t              q_item,
  output logic                             q_pop,
  input  logic                             pop,
  output logic                             empty,
  output logic [lbbf_pkg::ADDR_W-1:0]      out_row,
  output logic [lbbf_pkg::ADDR_W-1:0]      out_col,
  output logic [lbbf_pkg::PIX_W-1:0]       out_value,
  output logic                             run_last,
  output logic                             frame_last
);

  localparam int PW = lbbf_pkg::PIX_W;
  localparam int OLW = lbbf_pkg::OLVL_W;
  localparam int OPW = lbbf_pkg::OPTR_W;

  logic adv;

  // stage C: window
  logic                c_valid;
  lbbf_pkg::pix_meta_t c_meta;
  logic [PW-1:0]       win [5][5];

  // stage D: row sums
  logic                d_valid;
  lbbf_pkg::pix_meta_t d_meta;
  logic [10:0]         d_b5 [5];
  logic [11:0]         d_g5 [5];
  logic [9:0]          d_b3 [2:4];
  logic [9:0]          d_g3 [2:4];

  // stage E: kernel sum
  logic                e_valid;
  lbbf_pkg::pix_meta_t e_meta;
  logic [16:0]         e_sum;
  logic [16:0]         sum_sel;

  // stage F: quotient
  logic                f_valid;
  lbbf_pkg::pix_meta_t f_meta;
  logic [PW-1:0]       f_value;
  logic [25:0]         prod9;
  logic [26:0]         prod25;
  logic [25:0]         quo9;
  logic [26:0]         quo25;
  logic [PW-1:0]       value_sel;

  // result queue
  lbbf_pkg::result_t   oq [lbbf_pkg::ODEPTH];
  logic [OPW-1:0]      owp;
  logic [OPW-1:0]      orp;
  logic [OLW-1:0]      olevel;
  logic                o_wr;
  logic                o_rd;
  logic [OLW-1:0]      o_nwr;
  lbbf_pkg::result_t   res_pass;
  lbbf_pkg::result_t   res_filt;

  // Stall the whole pipe when stage F holds a result and the result queue cannot take two more words.
  assign adv   = !(f_valid && (olevel > OLW'(lbbf_pkg::ODEPTH - 2)));
  assign q_pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 5; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (adv) begin
      c_valid <= q_pop;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      if (q_pop) begin
        for (int r = 0; r < 5; r++) begin
          for (int c = 0; c < 4; c++) begin
            win[r][c] <= win[r][c+1];
          end
        end
        // oldest line at the top of the window
        for (int r = 0; r < 4; r++) begin
          win[r][4] <= q_item.lines[PW*(3-r) +: PW];
        end
        win[4][4] <= q_item.meta.px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_pop) begin
        c_meta <= q_item.meta;
      end
      d_meta <= c_meta;
      e_meta <= d_meta;
      f_meta <= e_meta;
      for (int r = 0; r < 5; r++) begin
        d_b5[r] <= 11'(win[r][0]) + 11'(win[r][1]) + 11'(win[r][2]) +
                   11'(win[r][3]) + 11'(win[r][4]);
        d_g5[r] <= 12'(win[r][0]) + (12'(win[r][1]) << 2) + 12'(win[r][2]) * 12'd6 +
                   (12'(win[r][3]) << 2) + 12'(win[r][4]);
      end
      for (int r = 2; r < 5; r++) begin
        d_b3[r] <= 10'(win[r][2]) + 10'(win[r][3]) + 10'(win[r][4]);
        d_g3[r] <= 10'(win[r][2]) + (10'(win[r][3]) << 1) + 10'(win[r][4]);
      end
      e_sum   <= sum_sel;
      f_value <= value_sel;
    end
  end

  always_comb begin
    case (filter_mode)
      lbbf_pkg::MODE_BOX3:
        sum_sel = 17'(d_b3[2]) + 17'(d_b3[3]) + 17'(d_b3[4]);
      lbbf_pkg::MODE_BOX5:
        sum_sel = 17'(d_b5[0]) + 17'(d_b5[1]) + 17'(d_b5[2]) +
                  17'(d_b5[3]) + 17'(d_b5[4]);
      lbbf_pkg::MODE_GAUSS3:
        sum_sel = 17'(d_g3[2]) + (17'(d_g3[3]) << 1) + 17'(d_g3[4]);
      lbbf_pkg::MODE_GAUSS5:
        sum_sel = 17'(d_g5[0]) + (17'(d_g5[1]) << 2) + 17'(d_g5[2]) * 17'd6 +
                  (17'(d_g5[3]) << 2) + 17'(d_g5[4]);
      default:
        sum_sel = '0;
    endcase
  end

  always_comb begin
    prod9  = 26'(e_sum[11:0]) * 26'(lbbf_pkg::RECIP9);
    prod25 = 27'(e_sum[12:0]) * 27'(lbbf_pkg::RECIP25);
    quo9   = prod9 >> lbbf_pkg::RECIP9_SHIFT;
    quo25  = prod25 >> lbbf_pkg::RECIP25_SHIFT;
    case (filter_mode)
      lbbf_pkg::MODE_BOX3:   value_sel = quo9[PW-1:0];
      lbbf_pkg::MODE_BOX5:   value_sel = quo25[PW-1:0];
      lbbf_pkg::MODE_GAUSS3: value_sel = e_sum[11:4];
      lbbf_pkg::MODE_GAUSS5: value_sel = e_sum[15:8];
      default:               value_sel = '0;
    endcase
  end

  // Pass-through word first, then the filtered word for an interior pixel.
  always_comb begin
    res_pass.row        = f_meta.row;
    res_pass.col        = f_meta.col;
    res_pass.value      = f_meta.px;
    res_pass.run_last   = !f_meta.filt;
    res_pass.frame_last = f_meta.frame_end && !f_meta.filt;
    res_filt.row        = f_meta.frow;
    res_filt.col        = f_meta.fcol;
    res_filt.value      = f_value;
    res_filt.run_last   = 1'b1;
    res_filt.frame_last = f_meta.frame_end;
  end

  assign o_wr  = f_valid && adv;
  assign o_rd  = pop && !empty;
  assign o_nwr = !o_wr ? OLW'(0) : (f_meta.filt ? OLW'(2) : OLW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= '0;
      orp    <= '0;
      olevel <= '0;
    end else begin
      owp    <= owp + OPW'(o_nwr);
      if (o_rd) begin
        orp <= orp + OPW'(1);
      end
      olevel <= olevel + o_nwr - OLW'(o_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (o_wr) begin
      oq[owp] <= res_pass;
      if (f_meta.filt) begin
        oq[owp + OPW'(1)] <= res_filt;
      end
    end
  end

  assign empty      = (olevel == '0);
  assign out_row    = oq[orp].row;
  assign out_col    = oq[orp].col;
  assign out_value  = oq[orp].value;
  assign run_last   = oq[orp].run_last;
  assign frame_last = oq[orp].frame_last;

endmodule

`default_nettype wire

// ----- src/line_buffer_blur_filter_core.sv -----
// Streaming 2-D blur over a raster pixel stream with four line stores.
// Instantiates lbbf_front, lbbf_queue and lbbf_back; uses lbbf_pkg.
//
// Usage:
//   Pixels enter in raster order on pixel_value, taken when push is high
//   and full is low. Each pixel yields one or two addressed writes on the
//   result side: its own value at (row, col), then for an interior pixel
//   the filtered value at the window center. run_last marks the last word
//   of a pixel, frame_last the last word of a frame. A word is shown while
//   empty is low and taken when pop is high.
//   Registers (filter_mode, image_width, image_height) are written through
//   cfg_wr_en / cfg_index / cfg_data while the block is idle.
// Timing:
//   A pixel can be taken every cycle while full is low. The result side
//   moves one word per cycle while pop is high, so interior pixels, at two
//   words each, run slower; the result queue depth sets how far the
//   pipeline runs ahead. The line store is one 32-bit RAM word per
//   column, read at accept and written back the next cycle.
// Reset and stalls:
//   Reset clears counters, queues and the window and loads default
//   registers. When pop is held low the result queue fills, the back end
//   stops, the middle queue fills and full rises; nothing is dropped.
`default_nettype none

module line_buffer_blur_filter_core #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lbbf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lbbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [lbbf_pkg::PIX_W-1:0]       pixel_value,
  input  logic                             pop,
  output logic                             empty,
  output logic [lbbf_pkg::ADDR_W-1:0]      out_row,
  output logic [lbbf_pkg::ADDR_W-1:0]      out_col,
  output logic [lbbf_pkg::PIX_W-1:0]       out_value,
  output logic                             run_last,
  output logic                             frame_last
);

  lbbf_pkg::qstat_t    q_stat;
  lbbf_pkg::col_item_t q_in;
  lbbf_pkg::col_item_t q_out;
  lbbf_pkg::mode_t     filter_mode;
  logic                q_push;
  logic                q_pop;

  lbbf_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .pixel_value (pixel_value),
    .full        (full),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_item      (q_in),
    .filter_mode (filter_mode)
  );

  lbbf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .pop  (q_pop),
    .dout (q_out),
    .stat (q_stat)
  );

  lbbf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .filter_mode (filter_mode),
    .q_stat      (q_stat),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .run_last    (run_last),
    .frame_last  (frame_last)
  );

endmodule

`default_nettype wire

// ----- src/lbbf_checker.sv -----
// Port-level checker for the blur filter core, bound to the top level.
// Uses the assertion macros of line_buffer_blur_filter_core_defines.svh.
`default_nettype none
`include "line_buffer_blur_filter_core_defines.svh"

module lbbf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        full,
  input logic                        pop,
  input logic                        empty,
  input logic [lbbf_pkg::ADDR_W-1:0] out_row,
  input logic [lbbf_pkg::ADDR_W-1:0] out_col,
  input logic [lbbf_pkg::PIX_W-1:0]  out_value,
  input logic                        run_last,
  input logic                        frame_last
);

  logic [2*lbbf_pkg::ADDR_W+lbbf_pkg::PIX_W+1:0] word_bits;

  assign word_bits = {out_row, out_col, out_value, run_last, frame_last};

  // reset drains both queues and frees the input side
  `LBBF_ASSERT_RESET(a_reset_clears, rst, empty && !full)

  // the frame's final word is always the last word of its pixel
  `LBBF_ASSERT_IMPL(a_frame_last_run_last, !empty && frame_last, run_last)

  // a waiting word holds until taken
  `LBBF_ASSERT_NEXT(a_word_holds, !empty && !pop, !empty && $stable(word_bits))

endmodule

bind line_buffer_blur_filter_core lbbf_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .out_row    (out_row),
  .out_col    (out_col),
  .out_value  (out_value),
  .run_last   (run_last),
  .frame_last (frame_last)
);

`default_nettype wire

// ----- tb/sv/tb_line_buffer_blur_filter_core.sv -----
// Self-checking testbench for line_buffer_blur_filter_core: directed and random streams.
// Each accepted word is checked against an in-bench predictor of the line stores and window.
// Depends on lbbf_pkg and the core RTL only.
module tb_line_buffer_blur_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 2048;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int WIDE_PIXELS = 64;
  localparam logic [lbbf_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [lbbf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lbbf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [lbbf_pkg::PIX_W-1:0] pixel_value = '0;
  logic pop = 1'b0;
  logic empty;
  logic [lbbf_pkg::ADDR_W-1:0] out_row;
  logic [lbbf_pkg::ADDR_W-1:0] out_col;
  logic [lbbf_pkg::PIX_W-1:0] out_value;
  logic run_last;
  logic frame_last;

  // Predictor state
  lbbf_pkg::mode_t mode_reg = lbbf_pkg::MODE_BOX3;
  logic [lbbf_pkg::CFG_DATA_W-1:0] width_reg = 12'd2048;
  logic [lbbf_pkg::CFG_DATA_W-1:0] height_reg = 12'd2048;
  logic [lbbf_pkg::PIX_W-1:0] line_mem [lbbf_pkg::LINES][MAX_DIM] = '{default: '0};
  logic [lbbf_pkg::PIX_W-1:0] window_px [5][5] = '{default: '0};
  logic [lbbf_pkg::ADDR_W-1:0] row_cnt = '0;
  logic [lbbf_pkg::ADDR_W-1:0] col_cnt = '0;

  lbbf_pkg::result_t exp_writes[$];
  int err_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  line_buffer_blur_filter_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .pixel_value(pixel_value),
    .pop(pop),
    .empty(empty),
    .out_row(out_row),
    .out_col(out_col),
    .out_value(out_value),
    .run_last(run_last),
    .frame_last(frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_dim(input logic [lbbf_pkg::CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [lbbf_pkg::PIX_W-1:0] window_blur();
    int unsigned k, base, acc, wt;
    int unsigned tap3 [3] = '{1, 2, 1};
    int unsigned tap5 [5] = '{1, 4, 6, 4, 1};
    k = (mode_reg == lbbf_pkg::MODE_BOX5 || mode_reg == lbbf_pkg::MODE_GAUSS5) ? 5 : 3;
    base = 5 - k;
    acc = 0;
    // 3x3 modes use the lower-right corner of the window
    for (int r = 0; r < k; r++) begin
      for (int c = 0; c < k; c++) begin
        case (mode_reg)
          lbbf_pkg::MODE_GAUSS3: wt = tap3[r] * tap3[c];
          lbbf_pkg::MODE_GAUSS5: wt = tap5[r] * tap5[c];
          default: wt = 1;
        endcase
        acc += window_px[base + r][base + c] * wt;
      end
    end
    case (mode_reg)
      lbbf_pkg::MODE_BOX3: acc = acc / 9;
      lbbf_pkg::MODE_BOX5: acc = acc / 25;
      lbbf_pkg::MODE_GAUSS3: acc = acc >> 4;
      default: acc = acc >> 8;
    endcase
    return acc[lbbf_pkg::PIX_W-1:0];
  endfunction

  task automatic predict_writes(input logic [lbbf_pkg::PIX_W-1:0] pix);
    int unsigned w_eff, h_eff, k, x, y;
    bit row_end, frame_end;
    lbbf_pkg::result_t wr;
    w_eff = eff_dim(width_reg);
    h_eff = eff_dim(height_reg);
    k = (mode_reg == lbbf_pkg::MODE_BOX5 || mode_reg == lbbf_pkg::MODE_GAUSS5) ? 5 : 3;
    x = col_cnt;
    y = row_cnt;
    row_end = (x + 1 >= w_eff);
    frame_end = row_end && (y + 1 >= h_eff);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 4; c++)
        window_px[r][c] = window_px[r][c + 1];
    for (int r = 0; r < lbbf_pkg::LINES; r++)
      window_px[r][4] = line_mem[lbbf_pkg::LINES - 1 - r][x];
    window_px[4][4] = pix;
    for (int r = lbbf_pkg::LINES - 1; r >= 1; r--)
      line_mem[r][x] = line_mem[r - 1][x];
    line_mem[0][x] = pix;
    wr.row = y[lbbf_pkg::ADDR_W-1:0];
    wr.col = x[lbbf_pkg::ADDR_W-1:0];
    wr.value = pix;
    wr.run_last = 1'b1;
    wr.frame_last = frame_end;
    if (w_eff >= k && h_eff >= k && y >= k - 1 && x >= k - 1) begin
      wr.run_last = 1'b0;
      wr.frame_last = 1'b0;
      exp_writes.push_back(wr);
      wr.row = lbbf_pkg::ADDR_W'(y - k / 2);
      wr.col = lbbf_pkg::ADDR_W'(x - k / 2);
      wr.value = window_blur();
      wr.run_last = 1'b1;
      wr.frame_last = frame_end;
    end
    exp_writes.push_back(wr);
    if (row_end) begin
      col_cnt = '0;
      row_cnt = frame_end ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  function automatic logic [lbbf_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return lbbf_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with push still high.
  task automatic send_pixel(input logic [lbbf_pkg::PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    pixel_value <= pix;
    do @(posedge clk); while (full);
    predict_writes(pix);
    @(negedge clk);
  endtask

  // Drain every pending word first so the block is idle when the register changes.
  task automatic write_reg(input logic [lbbf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lbbf_pkg::CFG_DATA_W-1:0] data);
    push <= 1'b0;
    while (exp_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      lbbf_pkg::REG_FILTER_MODE: mode_reg = lbbf_pkg::mode_t'(data[1:0]);
      lbbf_pkg::REG_IMAGE_WIDTH: width_reg = data;
      lbbf_pkg::REG_IMAGE_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // A wider row mid-frame would read line store columns the frame never wrote,
  // so finish the current frame first: a height of one ends it at the row end.
  task automatic resize(input logic [lbbf_pkg::CFG_DATA_W-1:0] w,
                        input logic [lbbf_pkg::CFG_DATA_W-1:0] h);
    if (eff_dim(w) > eff_dim(width_reg) && (row_cnt != 0 || col_cnt != 0)) begin
      write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 12'd1);
      while (row_cnt != 0 || col_cnt != 0) send_pixel(rand_pixel());
    end
    write_reg(lbbf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  task automatic test_defaults();
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_size_clamp();
    write_reg(lbbf_pkg::REG_FILTER_MODE, 12'hFFC);
    write_reg(REG_UNUSED, 12'hFFF);
    // zero sizes act as one: the column already sits past the row end
    resize(12'd0, 12'd0);
    send_pixel(8'h5A);
    send_pixel(8'hA5);
  endtask

  task automatic test_counter_overrun();
    int i;
    resize(12'd8, 12'd8);
    for (i = 0; i < 5; i++) send_pixel(rand_pixel());
    resize(12'd4, 12'd8);
    send_pixel(rand_pixel());
    write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 12'd1);
    for (i = 0; i < 4; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_kernel_too_big();
    int i;
    write_reg(lbbf_pkg::REG_FILTER_MODE, 12'(lbbf_pkg::MODE_BOX5));
    resize(12'd4, 12'd2);
    for (i = 0; i < 8; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_modes();
    int i;
    resize(12'd6, 12'd6);
    write_reg(lbbf_pkg::REG_FILTER_MODE, 12'(lbbf_pkg::MODE_GAUSS5));
    for (i = 0; i < 30; i++) send_pixel(8'hFF);
    // switch mid-frame; bits above the mode field must be ignored
    write_reg(lbbf_pkg::REG_FILTER_MODE, 12'hA00 | 12'(lbbf_pkg::MODE_BOX5));
    for (i = 0; i < 6; i++) send_pixel(i[0] ? 8'hFF : 8'h00);
  endtask

  // Oversized width clamps to the widest row; the row must not end early.
  task automatic test_widest_row();
    int i;
    resize(12'hFFF, 12'd0);
    for (i = 0; i < WIDE_PIXELS; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_backpressure();
    int i;
    resize(12'd8, 12'd6);
    write_reg(lbbf_pkg::REG_FILTER_MODE, 12'(lbbf_pkg::MODE_BOX5));
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    for (i = 0; i < 48; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_items);
    int sent, chunk, frame_px, i;
    logic [lbbf_pkg::CFG_DATA_W-1:0] w, h;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(7))
        0: begin
          w = lbbf_pkg::CFG_DATA_W'($urandom_range(1, 4));
          h = lbbf_pkg::CFG_DATA_W'($urandom_range(1, 4));
        end
        1: begin
          w = lbbf_pkg::CFG_DATA_W'($urandom_range(13, 48));
          h = lbbf_pkg::CFG_DATA_W'($urandom_range(5, 8));
        end
        default: begin
          w = lbbf_pkg::CFG_DATA_W'($urandom_range(3, 12));
          h = lbbf_pkg::CFG_DATA_W'($urandom_range(3, 8));
        end
      endcase
      resize(w, h);
      write_reg(lbbf_pkg::REG_FILTER_MODE, lbbf_pkg::CFG_DATA_W'($urandom));
      frame_px = eff_dim(w) * eff_dim(h);
      if ($urandom_range(3) == 0) chunk = $urandom_range(1, frame_px);
      else chunk = frame_px * $urandom_range(1, 2);
      for (i = 0; i < chunk && sent < n_items; i++) begin
        send_pixel(rand_pixel());
        sent++;
      end
    end
    send_idle = 0;
    recv_idle = 0;
  endtask

  // Result side: pop at random, or hold off while a long stall is pending.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic compare_field(input string what, input logic [lbbf_pkg::ADDR_W-1:0] want,
                               input logic [lbbf_pkg::ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    lbbf_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (exp_writes.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual row %0d col %0d value %0d",
                 $time, out_row, out_col, out_value);
        err_count++;
      end else begin
        want = exp_writes.pop_front();
        compare_field("out_row", want.row, out_row);
        compare_field("out_col", want.col, out_col);
        compare_field("out_value", lbbf_pkg::ADDR_W'(want.value),
                      lbbf_pkg::ADDR_W'(out_value));
        compare_field("run_last", lbbf_pkg::ADDR_W'(want.run_last),
                      lbbf_pkg::ADDR_W'(run_last));
        compare_field("frame_last", lbbf_pkg::ADDR_W'(want.frame_last),
                      lbbf_pkg::ADDR_W'(frame_last));
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_defaults();
    test_size_clamp();
    test_counter_overrun();
    test_kernel_too_big();
    test_modes();
    test_widest_row();
    test_backpressure();
    test_random_traffic(0, 0, 125);
    test_random_traffic(84, 0, 125);
    test_random_traffic(0, 84, 125);
    test_random_traffic(38, 38, 125);
    push <= 1'b0;
    while (exp_writes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
